### rtl/evg_pkg.sv
// Shared types, constants and tables of the ellipse vertex generator.
package evg_pkg;

  localparam int MAX_SEGMENTS      = 63;
  localparam int MIN_SEGMENTS      = 3;
  localparam int RESET_SEGMENTS    = 32;
  localparam int SEG_W             = 6;
  localparam int CORDIC_ITERATIONS = 16;
  localparam int ITER_PER_STAGE    = 4;
  localparam int CORDIC_STAGES     = (CORDIC_ITERATIONS + ITER_PER_STAGE - 1) / ITER_PER_STAGE;
  localparam int TRIG_W            = 20;
  localparam int HALF_PI_Q16       = 102944;
  localparam int CORDIC_GAIN_Q16   = 39797;
  localparam int DIV_STEPS         = 33;
  localparam int DIV_CNT_W         = 6;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] radius_x;
    logic signed [31:0] radius_y;
  } request_t;

  typedef struct packed {
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic [SEG_W-1:0]   vertex_number;
    logic               last_vertex;
  } vertex_t;

  // Sideband that travels with each angle through the rotator
  typedef struct packed {
    request_t         req;
    logic [1:0]       quad;
    logic [SEG_W-1:0] index;
    logic             last;
  } side_t;

  // Arctangent of 2^-k in Q.16 radians
  function automatic logic signed [TRIG_W-1:0] atan_q16(input int k);
    logic signed [TRIG_W-1:0] v;
    v = '0;
    case (k)
      0:  v = TRIG_W'(51472);
      1:  v = TRIG_W'(30386);
      2:  v = TRIG_W'(16055);
      3:  v = TRIG_W'(8150);
      4:  v = TRIG_W'(4091);
      5:  v = TRIG_W'(2047);
      6:  v = TRIG_W'(1024);
      7:  v = TRIG_W'(512);
      8:  v = TRIG_W'(256);
      9:  v = TRIG_W'(128);
      10: v = TRIG_W'(64);
      11: v = TRIG_W'(32);
      12: v = TRIG_W'(16);
      13: v = TRIG_W'(8);
      14: v = TRIG_W'(4);
      15: v = TRIG_W'(2);
      16: v = TRIG_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### rtl/ellipse_vertex_generator_core.sv
// Top level of the ellipse vertex generator: step divider, sequencer, datapath.
//
//  channel  | ports                        | beat taken when
//  ---------+------------------------------+------------------------------
//  request  | start, busy, in_data         | start high while busy low
//  vertex   | out_valid, out_data          | every cycle out_valid is high
//  config   | cfg_valid, cfg_ready, cfg_data | cfg_valid and cfg_ready high
//
// A request with both radii positive keeps busy high while its N+1 vertices
// (N = clamped segment count) enter the datapath, one per cycle; the next
// request is taken right after. Vertices pass the angle, CORDIC, scale and
// output registers. A config write holds busy while a bit-serial divider
// forms the per-vertex phase step 2^32/N. Reset is synchronous and gives
// N = 32. Results cannot be held off, so the datapath never stalls.
module ellipse_vertex_generator_core import evg_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  request_t         in_data,
  output logic             out_valid,
  output vertex_t          out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [SEG_W-1:0] cfg_data
);

  // Segment count and phase step (quotient and remainder of 2^32 / N)
  logic [SEG_W-1:0]     n_r, n_nxt;
  logic [31:0]          dv_quo_r, dv_quo_nxt;
  logic [SEG_W-1:0]     dv_rem_r, dv_rem_nxt;
  logic                 dv_active_r, dv_active_nxt;
  logic [DIV_CNT_W-1:0] dv_cnt_r, dv_cnt_nxt;
  logic [SEG_W:0]       dv_trial;

  // Sequencer
  logic                 seq_active_r, seq_active_nxt;
  logic [SEG_W-1:0]     idx_r, idx_nxt;
  logic [31:0]          acc_q_r, acc_q_nxt;
  logic [SEG_W-1:0]     acc_r_r, acc_r_nxt;
  request_t             req_r, req_nxt;
  logic [SEG_W:0]       rem_sum;
  logic                 rem_carry;
  logic                 in_take, radii_ok, cfg_take;

  // Angle stage
  logic                 a_vld_r;
  side_t                a_side_r;
  logic signed [TRIG_W-1:0] a_z_r;
  logic [47:0]          ang_prod;

  // Rotator output
  logic                 c_vld;
  side_t                c_side;
  logic signed [TRIG_W-1:0] c_x, c_y;

  // Scale stage
  logic                 m_vld_r;
  side_t                m_side_r;
  logic signed [51:0]   m_px_r, m_py_r;
  logic signed [TRIG_W-1:0] cos_v, sin_v;

  logic                 out_valid_r;
  vertex_t              out_data_r;

  assign busy      = seq_active_r | dv_active_r;
  assign cfg_ready = !busy && !start;
  assign in_take   = start && !busy;
  assign cfg_take  = cfg_valid && cfg_ready;
  assign radii_ok  = !in_data.radius_x[31] && (in_data.radius_x != '0) &&
                     !in_data.radius_y[31] && (in_data.radius_y != '0);

  // Clamp N, then restoring division of 2^32 by N, one quotient bit per cycle
  always_comb begin
    n_nxt         = n_r;
    dv_quo_nxt    = dv_quo_r;
    dv_rem_nxt    = dv_rem_r;
    dv_active_nxt = dv_active_r;
    dv_cnt_nxt    = dv_cnt_r;
    dv_trial      = {dv_rem_r, (dv_cnt_r == DIV_CNT_W'(DIV_STEPS))};
    if (cfg_take) begin
      if (cfg_data < SEG_W'(MIN_SEGMENTS)) begin
        n_nxt = SEG_W'(MIN_SEGMENTS);
      end else if (cfg_data > SEG_W'(MAX_SEGMENTS)) begin
        n_nxt = SEG_W'(MAX_SEGMENTS);
      end else begin
        n_nxt = cfg_data;
      end
      dv_quo_nxt    = '0;
      dv_rem_nxt    = '0;
      dv_active_nxt = 1'b1;
      dv_cnt_nxt    = DIV_CNT_W'(DIV_STEPS);
    end else if (dv_active_r) begin
      if (dv_trial >= {1'b0, n_r}) begin
        dv_rem_nxt = SEG_W'(dv_trial - {1'b0, n_r});
        dv_quo_nxt = {dv_quo_r[30:0], 1'b1};
      end else begin
        dv_rem_nxt = dv_trial[SEG_W-1:0];
        dv_quo_nxt = {dv_quo_r[30:0], 1'b0};
      end
      dv_cnt_nxt = dv_cnt_r - 1'b1;
      if (dv_cnt_r == DIV_CNT_W'(1)) begin
        dv_active_nxt = 1'b0;
      end
    end
  end

  // Advance the phase by the step, carrying the remainder
  always_comb begin
    rem_sum   = {1'b0, acc_r_r} + {1'b0, dv_rem_r};
    rem_carry = (rem_sum >= {1'b0, n_r});
    seq_active_nxt = seq_active_r;
    idx_nxt        = idx_r;
    acc_q_nxt      = acc_q_r;
    acc_r_nxt      = acc_r_r;
    req_nxt        = req_r;
    if (in_take && radii_ok) begin
      seq_active_nxt = 1'b1;
      idx_nxt        = '0;
      acc_q_nxt      = '0;
      acc_r_nxt      = '0;
      req_nxt        = in_data;
    end else if (seq_active_r) begin
      idx_nxt   = idx_r + 1'b1;
      acc_q_nxt = acc_q_r + dv_quo_r + 32'(rem_carry);
      acc_r_nxt = rem_carry ? SEG_W'(rem_sum - {1'b0, n_r}) : rem_sum[SEG_W-1:0];
      if (idx_r == n_r) begin
        seq_active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r          <= SEG_W'(RESET_SEGMENTS);
      dv_quo_r     <= 32'd1 << 27;
      dv_rem_r     <= '0;
      dv_active_r  <= 1'b0;
      dv_cnt_r     <= '0;
      seq_active_r <= 1'b0;
      idx_r        <= '0;
      acc_q_r      <= '0;
      acc_r_r      <= '0;
    end else begin
      n_r          <= n_nxt;
      dv_quo_r     <= dv_quo_nxt;
      dv_rem_r     <= dv_rem_nxt;
      dv_active_r  <= dv_active_nxt;
      dv_cnt_r     <= dv_cnt_nxt;
      seq_active_r <= seq_active_nxt;
      idx_r        <= idx_nxt;
      acc_q_r      <= acc_q_nxt;
      acc_r_r      <= acc_r_nxt;
    end
    req_r <= req_nxt;
  end

  // Turn the in-quadrant phase into Q.16 radians
  assign ang_prod = {18'd0, acc_q_r[29:0]} * 48'(HALF_PI_Q16) + (48'd1 << 29);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= seq_active_r;
    end
    a_side_r.req   <= req_r;
    a_side_r.quad  <= acc_q_r[31:30];
    a_side_r.index <= idx_r;
    a_side_r.last  <= (idx_r == n_r);
    a_z_r          <= TRIG_W'(ang_prod[47:30]);
  end

  evg_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (a_vld_r),
    .in_side   (a_side_r),
    .in_z      (a_z_r),
    .out_valid (c_vld),
    .out_side  (c_side),
    .out_x     (c_x),
    .out_y     (c_y)
  );

  // Unfold the quadrant, then scale by the radii
  always_comb begin
    case (c_side.quad)
      2'd0: begin
        cos_v = c_x;
        sin_v = c_y;
      end
      2'd1: begin
        cos_v = -c_y;
        sin_v = c_x;
      end
      2'd2: begin
        cos_v = -c_x;
        sin_v = -c_y;
      end
      default: begin
        cos_v = c_y;
        sin_v = -c_x;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else begin
      m_vld_r <= c_vld;
    end
    m_side_r <= c_side;
    m_px_r   <= 52'(c_side.req.radius_x) * 52'(cos_v);
    m_py_r   <= 52'(c_side.req.radius_y) * 52'(sin_v);
  end

  // Round the product to nearest, add the centre and saturate
  function automatic logic signed [31:0] place(input logic signed [31:0] centre,
                                               input logic signed [51:0] prod);
    logic signed [51:0] sh;
    logic signed [37:0] sum;
    sh  = (prod + 52'sd32768) >>> 16;
    sum = 38'(centre) + $signed(sh[37:0]);
    if (sum > 38'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (sum < -38'sd2147483648) begin
      return 32'sh80000000;
    end
    return sum[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= m_vld_r;
    end
    out_data_r.vertex_x      <= place(m_side_r.req.center_x, m_px_r);
    out_data_r.vertex_y      <= place(m_side_r.req.center_y, m_py_r);
    out_data_r.vertex_number <= m_side_r.index;
    out_data_r.last_vertex   <= m_side_r.last;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/evg_cordic.sv
// Pipelined rotation-mode CORDIC, ITER_PER_STAGE iterations per register stage.
module evg_cordic import evg_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  side_t                    in_side,
  input  logic signed [TRIG_W-1:0] in_z,
  output logic                     out_valid,
  output side_t                    out_side,
  output logic signed [TRIG_W-1:0] out_x,
  output logic signed [TRIG_W-1:0] out_y
);

  logic                     vld_r  [1:CORDIC_STAGES];
  side_t                    side_r [1:CORDIC_STAGES];
  logic signed [TRIG_W-1:0] x_r    [1:CORDIC_STAGES];
  logic signed [TRIG_W-1:0] y_r    [1:CORDIC_STAGES];
  logic signed [TRIG_W-1:0] z_r    [1:CORDIC_STAGES];

  logic                     src_vld  [0:CORDIC_STAGES-1];
  side_t                    src_side [0:CORDIC_STAGES-1];
  logic signed [TRIG_W-1:0] src_x    [0:CORDIC_STAGES-1];
  logic signed [TRIG_W-1:0] src_y    [0:CORDIC_STAGES-1];
  logic signed [TRIG_W-1:0] src_z    [0:CORDIC_STAGES-1];

  // Feed the first stage with the gain-scaled unit vector
  assign src_vld[0]  = in_valid;
  assign src_side[0] = in_side;
  assign src_x[0]    = TRIG_W'(CORDIC_GAIN_Q16);
  assign src_y[0]    = '0;
  assign src_z[0]    = in_z;

  for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_stage
    logic signed [TRIG_W-1:0] x_nxt, y_nxt, z_nxt;

    if (s > 0) begin : g_link
      assign src_vld[s]  = vld_r[s];
      assign src_side[s] = side_r[s];
      assign src_x[s]    = x_r[s];
      assign src_y[s]    = y_r[s];
      assign src_z[s]    = z_r[s];
    end

    // Rotate towards zero residual angle
    always_comb begin
      logic signed [TRIG_W-1:0] dx, dy;
      dx    = '0;
      dy    = '0;
      x_nxt = src_x[s];
      y_nxt = src_y[s];
      z_nxt = src_z[s];
      for (int j = 0; j < ITER_PER_STAGE; j++) begin
        if (s * ITER_PER_STAGE + j < CORDIC_ITERATIONS) begin
          dx = y_nxt >>> (s * ITER_PER_STAGE + j);
          dy = x_nxt >>> (s * ITER_PER_STAGE + j);
          if (!z_nxt[TRIG_W-1]) begin
            x_nxt = x_nxt - dx;
            y_nxt = y_nxt + dy;
            z_nxt = z_nxt - atan_q16(s * ITER_PER_STAGE + j);
          end else begin
            x_nxt = x_nxt + dx;
            y_nxt = y_nxt - dy;
            z_nxt = z_nxt + atan_q16(s * ITER_PER_STAGE + j);
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else begin
        vld_r[s+1] <= src_vld[s];
      end
      side_r[s+1] <= src_side[s];
      x_r[s+1]    <= x_nxt;
      y_r[s+1]    <= y_nxt;
      z_r[s+1]    <= z_nxt;
    end
  end

  assign out_valid = vld_r[CORDIC_STAGES];
  assign out_side  = side_r[CORDIC_STAGES];
  assign out_x     = x_r[CORDIC_STAGES];
  assign out_y     = y_r[CORDIC_STAGES];

endmodule

### rtl/evg_checker.sv
// Port-level checks of the ellipse vertex generator, bound to the top level.
module evg_checker import evg_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input request_t         in_data,
  input logic             out_valid,
  input vertex_t          out_data,
  input logic             cfg_valid,
  input logic             cfg_ready,
  input logic [SEG_W-1:0] cfg_data
);

  // Vertices of one ring leave in consecutive cycles
  a_ring_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_vertex |=>
      out_valid && (out_data.vertex_number == $past(out_data.vertex_number) + 1'b1))
    else $error("ring broken before its closing vertex");

  // A ring closes after at least three segments
  a_ring_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_vertex |-> out_data.vertex_number >= SEG_W'(MIN_SEGMENTS))
    else $error("ring closed too early");

  // A config beat starts the step divider
  a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> busy)
    else $error("config beat did not raise busy");

  // A request whose x radius is not positive is dropped and leaves busy low
  a_bad_radius: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !(cfg_valid && cfg_ready) &&
    (in_data.radius_x[31] || in_data.radius_x == '0) |=> !busy)
    else $error("rejected request raised busy");

endmodule

bind ellipse_vertex_generator_core evg_checker u_evg_checker (.*);

### tb/tb_ellipse_vertex_generator_core.sv
// Self-checking testbench of the ellipse vertex generator core.
`timescale 1ns / 100ps

module tb_ellipse_vertex_generator_core;
  import evg_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int RANDOM_ITEMS   = 180;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_NONE, ROW_SAT_X0} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    request_t    req;
    logic [31:0] x0;
  } stim_row_t;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  request_t         in_data;
  logic             out_valid;
  vertex_t          out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [SEG_W-1:0] cfg_data;

  vertex_t          pending_vertices[$];
  logic [SEG_W-1:0] seg_setting;
  int               fail_count;
  int               idle_cycles;
  stim_row_t        stim_table[$];

  ellipse_vertex_generator_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Rotation-mode CORDIC after quadrant reduction, values in Q.16
  task automatic unit_sincos(input logic [31:0] phase, output longint c, output longint s);
    longint x, y, z, dx, dy;
    logic [63:0] r;
    x = CORDIC_GAIN_Q16;
    y = 0;
    r = {34'b0, phase[29:0]};
    z = longint'((r * 64'(HALF_PI_Q16) + 64'(1) * (64'(1) << 29)) >> 30);
    for (int k = 0; k < CORDIC_ITERATIONS; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_q16(k));
      end else begin
        x += dx; y -= dy; z += longint'(atan_q16(k));
      end
    end
    case (phase[31:30])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  // Centre plus rounded product, clamped to 32 bits
  function automatic logic [31:0] scaled_coord(longint centre, longint radius, longint trig);
    longint v;
    v = centre + ((radius * trig + 32768) >>> 16);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  // Queue the ring of vertices that a request produces at the current setting
  task automatic predict_ring(input request_t req);
    int unsigned n;
    logic [63:0] step;
    longint c, s;
    vertex_t v;
    if (req.radius_x <= 0 || req.radius_y <= 0) return;
    n = seg_setting;
    if (n < MIN_SEGMENTS) n = MIN_SEGMENTS;
    if (n > MAX_SEGMENTS) n = MAX_SEGMENTS;
    for (int unsigned i = 0; i <= n; i++) begin
      step = (64'(i) << 32) / 64'(n);
      unit_sincos(step[31:0], c, s);
      v.vertex_x      = scaled_coord(longint'(req.center_x), longint'(req.radius_x), c);
      v.vertex_y      = scaled_coord(longint'(req.center_y), longint'(req.radius_y), s);
      v.vertex_number = SEG_W'(i);
      v.last_vertex   = (i == n);
      pending_vertices.insert(pending_vertices.size(), v);
    end
  endtask

  // Compare each vertex beat with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_vertices.size() == 0) begin
        $display("%0t: unexpected vertex x=%h y=%h n=%0d last=%b", $time,
                 out_data.vertex_x, out_data.vertex_y, out_data.vertex_number,
                 out_data.last_vertex);
        fail_count++;
      end else begin
        if (out_data !== pending_vertices[0]) begin
          $display("%0t: vertex mismatch expected x=%h y=%h n=%0d last=%b", $time,
                   pending_vertices[0].vertex_x, pending_vertices[0].vertex_y,
                   pending_vertices[0].vertex_number, pending_vertices[0].last_vertex);
          $display("%0t:                 actual   x=%h y=%h n=%0d last=%b", $time,
                   out_data.vertex_x, out_data.vertex_y, out_data.vertex_number,
                   out_data.last_vertex);
          fail_count++;
        end
        void'(pending_vertices.pop_front());
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_request(input request_t req, input int gap, input bit force_none,
                              input bit check_x0, input logic [31:0] x0);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (busy);
    if (!force_none) begin
      predict_ring(req);
      if (check_x0) pending_vertices[pending_vertices.size() - (seg_setting < 3 ? 4 :
        seg_setting + 1)].vertex_x = x0;
    end
  endtask

  // Drain every expected vertex, then let the datapath settle
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_segments(input logic [SEG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    seg_setting = value;
  endtask

  function automatic request_t random_request();
    request_t r;
    r.center_x = $urandom;
    r.center_y = $urandom;
    case ($urandom_range(0, 9))
      0: begin r.radius_x = $urandom; r.radius_y = $urandom; end
      1: begin r.radius_x = -$urandom_range(0, 1000); r.radius_y = $urandom_range(1, 1 << 20); end
      2, 3: begin
        r.radius_x = {1'b0, 31'($urandom)};
        r.radius_y = {1'b0, 31'($urandom)};
        if (r.radius_x == 0) r.radius_x = 1;
        if (r.radius_y == 0) r.radius_y = 1;
      end
      default: begin
        r.center_x = $signed($urandom_range(0, 1 << 26)) - (1 << 25);
        r.center_y = $signed($urandom_range(0, 1 << 26)) - (1 << 25);
        r.radius_x = $urandom_range(1, 1 << 24);
        r.radius_y = $urandom_range(1, 1 << 24);
      end
    endcase
    return r;
  endfunction

  function automatic stim_row_t make_row(row_kind_t kind, logic [31:0] cx, logic [31:0] cy,
                                          logic [31:0] rx, logic [31:0] ry, logic [31:0] x0);
    stim_row_t row;
    row.kind = kind;
    row.req  = '{center_x: cx, center_y: cy, radius_x: rx, radius_y: ry};
    row.x0   = x0;
    return row;
  endfunction

  // Append one row to the stimulus table
  task automatic add_row(input stim_row_t row);
    stim_table.insert(stim_table.size(), row);
  endtask

  initial begin
    logic [SEG_W-1:0] settings[$];
    bit               burst;
    int               per_phase;
    stim_row_t        row;

    rst_n       = 1'b0;
    start       = 1'b0;
    in_data     = '0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    seg_setting = SEG_W'(RESET_SEGMENTS);
    fail_count  = 0;
    idle_cycles = 0;

    // Directed rows: extremes, ignored requests and saturation
    add_row(make_row(ROW_NONE, 0, 0, 0, 0, 0));
    add_row(make_row(ROW_NONE, 0, 0, 32'h8000_0000, 32'h0001_0000, 0));
    add_row(make_row(ROW_NONE, 0, 0, 32'h0001_0000, 32'h8000_0000, 0));
    add_row(make_row(ROW_NONE, 32'h7FFF_FFFF, 0, 32'h0001_0000, 0, 0));
    add_row(make_row(ROW_NONE, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0));
    add_row(make_row(ROW_PREDICT, 0, 0, 32'h0001_0000, 32'h0001_0000, 0));
    add_row(make_row(ROW_PREDICT, 0, 0, 1, 1, 0));
    add_row(make_row(ROW_PREDICT, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
    add_row(make_row(ROW_SAT_X0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    add_row(make_row(ROW_PREDICT, 32'h8000_0000, 32'h8000_0000,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
    add_row(make_row(ROW_PREDICT, 32'hFFF0_0000, 32'h0010_0000,
                     32'h0003_0000, 32'h0000_8000, 0));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows at the reset setting
    foreach (stim_table[j]) begin
      row = stim_table[j];
      send_request(row.req, $urandom_range(0, 3), row.kind == ROW_NONE,
                   row.kind == ROW_SAT_X0, row.x0);
    end
    wait_idle();

    // Walk the settings, extremes and clamped values among them
    settings = '{6'd3, 6'd63, 6'd0, 6'd17, 6'd1, 6'd2, 6'($urandom_range(4, 62))};
    per_phase = RANDOM_ITEMS / settings.size();
    foreach (settings[p]) begin
      write_segments(settings[p]);
      burst = ($urandom_range(0, 2) == 0);
      for (int j = 0; j < per_phase; j++)
        send_request(random_request(), burst ? 0 : $urandom_range(0, 19), 1'b0, 1'b0, 0);
      wait_idle();
    end

    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

### filelist.f
rtl/evg_pkg.sv
rtl/evg_cordic.sv
rtl/ellipse_vertex_generator_core.sv
rtl/evg_checker.sv
tb/tb_ellipse_vertex_generator_core.sv
